[src/rational_add_sub_compare_top_macros.svh]
// assertion macros for the rational add/sub/compare block
`ifndef RATIONAL_ADD_SUB_COMPARE_TOP_MACROS_SVH
`define RATIONAL_ADD_SUB_COMPARE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RASC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rasc assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define RASC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rasc assertion failed");

`endif

[src/rasc_pkg.sv]
// shared types and constants of the rational add/sub/compare block
`default_nettype none
package rasc_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned NUM_W      = 32;
  localparam int unsigned DEN_W      = 31;
  localparam int unsigned WIDE_W     = 64;
  localparam int unsigned SHIFT_W    = 6;
  localparam int unsigned DCNT_W     = 7;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [WIDE_W-1:0] RES_MAX = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
  localparam logic [WIDE_W-1:0] RES_NEG_MAG = RES_MAX + 64'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic                    op;
    logic signed [NUM_W-1:0] a_num;
    logic [DEN_W-1:0]        a_den;
    logic signed [NUM_W-1:0] b_num;
    logic [DEN_W-1:0]        b_den;
    logic                    zero_den;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [WIDE_W-1:0] u;
    logic [WIDE_W-1:0] v;
  } gcd_req_t;

  typedef struct packed {
    logic              done;
    logic [WIDE_W-1:0] g;
  } gcd_rsp_t;

  typedef struct packed {
    logic              start;
    logic [WIDE_W-1:0] num;
    logic [WIDE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WIDE_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    SQ_IDLE,
    SQ_CMP_L,
    SQ_CMP_R,
    SQ_GCD1_GO,
    SQ_GCD1_WAIT,
    SQ_DIVA_GO,
    SQ_DIVA_WAIT,
    SQ_DIVB_GO,
    SQ_DIVB_WAIT,
    SQ_MUL_A,
    SQ_MUL_B,
    SQ_MUL_DEN,
    SQ_SUM,
    SQ_GCD2_GO,
    SQ_GCD2_WAIT,
    SQ_DIVN_GO,
    SQ_DIVN_WAIT,
    SQ_DIVD_GO,
    SQ_DIVD_WAIT,
    SQ_WRITE
  } seq_e;

endpackage
`default_nettype wire

[src/rasc_req_if.sv]
// request channel: two fractions and the operation
`default_nettype none
interface rasc_req_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic signed [rasc_pkg::NUM_W-1:0]  a_num;
  logic [rasc_pkg::DEN_W-1:0]         a_den;
  logic signed [rasc_pkg::NUM_W-1:0]  b_num;
  logic [rasc_pkg::DEN_W-1:0]         b_den;

  modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface
`default_nettype wire

[src/rasc_res_if.sv]
// result channel: reduced fraction, compare flags and status
`default_nettype none
interface rasc_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [rasc_pkg::NUM_W-1:0]  res_num;
  logic [rasc_pkg::DEN_W-1:0]         res_den;
  logic                               a_less;
  logic                               a_equal;
  logic                               a_greater;
  logic [1:0]                         status;

  modport source (output valid, res_num, res_den, a_less, a_equal, a_greater, status,
                  input ready);
  modport sink (input valid, res_num, res_den, a_less, a_equal, a_greater, status,
                output ready);
endinterface
`default_nettype wire

[src/rasc_front.sv]
// front end: takes requests, flags zero denominators, queues them
`default_nettype none
module rasc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  rasc_req_if.sink             req_i,
  output rasc_pkg::item_t      item_o,
  output logic                 item_valid_o,
  input  wire logic            item_ready_i
);

  rasc_pkg::item_t                   mem_q [rasc_pkg::QUEUE_DEPTH];
  logic [rasc_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [rasc_pkg::QCNT_W-1:0]       cnt_q;
  logic                              push, pop;
  rasc_pkg::item_t                   item_in;

  always_comb begin
    item_in.op       = req_i.op;
    item_in.a_num    = req_i.a_num;
    item_in.a_den    = req_i.a_den;
    item_in.b_num    = req_i.b_num;
    item_in.b_den    = req_i.b_den;
    item_in.zero_den = (req_i.a_den == '0) || (req_i.b_den == '0);
  end

  assign req_i.ready  = (cnt_q != rasc_pkg::QCNT_W'(rasc_pkg::QUEUE_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = req_i.valid && req_i.ready;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item_in;
  end

endmodule
`default_nettype wire

[src/rasc_gcd.sv]
// iterative binary gcd, one step a cycle
`default_nettype none
module rasc_gcd (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rasc_pkg::gcd_req_t req_i,
  output rasc_pkg::gcd_rsp_t      rsp_o
);

  logic [rasc_pkg::WIDE_W-1:0]  u_q, v_q, g_q;
  logic [rasc_pkg::SHIFT_W-1:0] k_q;
  logic                         busy_q, done_q;

  assign rsp_o.done = done_q;
  assign rsp_o.g    = g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && ((v_q == '0) || (u_q == '0))) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      u_q <= req_i.u;
      v_q <= req_i.v;
      k_q <= '0;
    end else if (busy_q) begin
      if (v_q == '0) begin
        g_q <= u_q << k_q;
      end else if (u_q == '0) begin
        g_q <= v_q << k_q;
      end else if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= v_q;
        v_q <= u_q - v_q;
      end else begin
        v_q <= v_q - u_q;
      end
    end
  end

endmodule
`default_nettype wire

[src/rasc_div.sv]
// restoring divider, one quotient bit a cycle
`default_nettype none
module rasc_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rasc_pkg::div_req_t req_i,
  output rasc_pkg::div_rsp_t      rsp_o
);

  logic [rasc_pkg::WIDE_W-1:0] quo_q, den_q;
  logic [rasc_pkg::WIDE_W:0]   rem_q, rem_sh, diff;
  logic [rasc_pkg::DCNT_W-1:0] cnt_q;
  logic                        busy_q, done_q;

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rem_sh     = {rem_q[rasc_pkg::WIDE_W-1:0], quo_q[rasc_pkg::WIDE_W-1]};
  assign diff       = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= rasc_pkg::DCNT_W'(rasc_pkg::WIDE_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == rasc_pkg::DCNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[rasc_pkg::WIDE_W]) begin
        rem_q <= diff;
        quo_q <= {quo_q[rasc_pkg::WIDE_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[rasc_pkg::WIDE_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

[src/rasc_back.sv]
// back end: sequencer over a shared multiplier, gcd unit and divider
`default_nettype none
module rasc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rasc_pkg::item_t item_i,
  input  wire logic            item_valid_i,
  output logic                 item_ready_o,
  rasc_res_if.source           res_o
);

  localparam int unsigned W  = rasc_pkg::WIDE_W;
  localparam int unsigned NW = rasc_pkg::NUM_W;
  localparam int unsigned DW = rasc_pkg::DEN_W;

  rasc_pkg::seq_e              state_q, state_d;
  rasc_pkg::item_t             item_q;
  rasc_pkg::gcd_req_t          gcd_req;
  rasc_pkg::gcd_rsp_t          gcd_rsp;
  rasc_pkg::div_req_t          div_req;
  rasc_pkg::div_rsp_t          div_rsp;

  logic signed [W-1:0]         lhs_q, rhs_q, pa_q, pb_q, num;
  logic [DW-1:0]               g_q, fa_q, fb_q;
  logic [W-1:0]                mag_q, den_q, d_q, rmag_q, rden_q, sn;
  logic                        neg_q, ovf, out_free;
  logic signed [NW:0]          mul_a, mul_b;
  logic signed [2*NW+1:0]      prod;

  logic                        out_valid_q;
  logic signed [NW-1:0]        out_num_q;
  logic [DW-1:0]               out_den_q;
  logic                        out_lt_q, out_eq_q, out_gt_q;
  rasc_pkg::status_e           out_status_q;

  rasc_gcd u_gcd (.clk_i, .rst_ni, .req_i(gcd_req), .rsp_o(gcd_rsp));
  rasc_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  assign out_free = !out_valid_q || res_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rasc_pkg::SQ_IDLE: begin
        if (item_valid_i) begin
          state_d = item_i.zero_den ? rasc_pkg::SQ_WRITE : rasc_pkg::SQ_CMP_L;
        end
      end
      rasc_pkg::SQ_CMP_L:     state_d = rasc_pkg::SQ_CMP_R;
      rasc_pkg::SQ_CMP_R:     state_d = rasc_pkg::SQ_GCD1_GO;
      rasc_pkg::SQ_GCD1_GO:   state_d = rasc_pkg::SQ_GCD1_WAIT;
      rasc_pkg::SQ_GCD1_WAIT: if (gcd_rsp.done) state_d = rasc_pkg::SQ_DIVA_GO;
      rasc_pkg::SQ_DIVA_GO:   state_d = rasc_pkg::SQ_DIVA_WAIT;
      rasc_pkg::SQ_DIVA_WAIT: if (div_rsp.done) state_d = rasc_pkg::SQ_DIVB_GO;
      rasc_pkg::SQ_DIVB_GO:   state_d = rasc_pkg::SQ_DIVB_WAIT;
      rasc_pkg::SQ_DIVB_WAIT: if (div_rsp.done) state_d = rasc_pkg::SQ_MUL_A;
      rasc_pkg::SQ_MUL_A:     state_d = rasc_pkg::SQ_MUL_B;
      rasc_pkg::SQ_MUL_B:     state_d = rasc_pkg::SQ_MUL_DEN;
      rasc_pkg::SQ_MUL_DEN:   state_d = rasc_pkg::SQ_SUM;
      rasc_pkg::SQ_SUM:       state_d = rasc_pkg::SQ_GCD2_GO;
      rasc_pkg::SQ_GCD2_GO:   state_d = rasc_pkg::SQ_GCD2_WAIT;
      rasc_pkg::SQ_GCD2_WAIT: if (gcd_rsp.done) state_d = rasc_pkg::SQ_DIVN_GO;
      rasc_pkg::SQ_DIVN_GO:   state_d = rasc_pkg::SQ_DIVN_WAIT;
      rasc_pkg::SQ_DIVN_WAIT: if (div_rsp.done) state_d = rasc_pkg::SQ_DIVD_GO;
      rasc_pkg::SQ_DIVD_GO:   state_d = rasc_pkg::SQ_DIVD_WAIT;
      rasc_pkg::SQ_DIVD_WAIT: if (div_rsp.done) state_d = rasc_pkg::SQ_WRITE;
      rasc_pkg::SQ_WRITE:     if (out_free) state_d = rasc_pkg::SQ_IDLE;
      default:                state_d = rasc_pkg::SQ_IDLE;
    endcase
  end

  // control outputs: unit launches and multiplier operands
  always_comb begin
    item_ready_o  = 1'b0;
    gcd_req       = '0;
    div_req       = '0;
    mul_a         = '0;
    mul_b         = '0;
    case (state_q)
      rasc_pkg::SQ_IDLE: item_ready_o = 1'b1;
      rasc_pkg::SQ_CMP_L: begin
        mul_a = {item_q.a_num[NW-1], item_q.a_num};
        mul_b = {2'b00, item_q.b_den};
      end
      rasc_pkg::SQ_CMP_R: begin
        mul_a = {item_q.b_num[NW-1], item_q.b_num};
        mul_b = {2'b00, item_q.a_den};
      end
      rasc_pkg::SQ_GCD1_GO: begin
        gcd_req.start = 1'b1;
        gcd_req.u     = {{(W-DW){1'b0}}, item_q.a_den};
        gcd_req.v     = {{(W-DW){1'b0}}, item_q.b_den};
      end
      rasc_pkg::SQ_DIVA_GO: begin
        div_req.start = 1'b1;
        div_req.num   = {{(W-DW){1'b0}}, item_q.b_den};
        div_req.den   = {{(W-DW){1'b0}}, g_q};
      end
      rasc_pkg::SQ_DIVB_GO: begin
        div_req.start = 1'b1;
        div_req.num   = {{(W-DW){1'b0}}, item_q.a_den};
        div_req.den   = {{(W-DW){1'b0}}, g_q};
      end
      rasc_pkg::SQ_MUL_A: begin
        mul_a = {item_q.a_num[NW-1], item_q.a_num};
        mul_b = {2'b00, fa_q};
      end
      rasc_pkg::SQ_MUL_B: begin
        mul_a = {item_q.b_num[NW-1], item_q.b_num};
        mul_b = {2'b00, fb_q};
      end
      rasc_pkg::SQ_MUL_DEN: begin
        mul_a = {2'b00, fb_q};
        mul_b = {2'b00, item_q.b_den};
      end
      rasc_pkg::SQ_GCD2_GO: begin
        gcd_req.start = 1'b1;
        gcd_req.u     = mag_q;
        gcd_req.v     = den_q;
      end
      rasc_pkg::SQ_DIVN_GO: begin
        div_req.start = 1'b1;
        div_req.num   = mag_q;
        div_req.den   = d_q;
      end
      rasc_pkg::SQ_DIVD_GO: begin
        div_req.start = 1'b1;
        div_req.num   = den_q;
        div_req.den   = d_q;
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign num  = item_q.op ? (pa_q - pb_q) : (pa_q + pb_q);

  // range check of the reduced result
  assign ovf = (rden_q > rasc_pkg::RES_MAX) ||
               (neg_q ? (rmag_q > rasc_pkg::RES_NEG_MAG) : (rmag_q > rasc_pkg::RES_MAX));
  assign sn  = neg_q ? (W'(0) - rmag_q) : rmag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rasc_pkg::SQ_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rasc_pkg::SQ_WRITE && out_free) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      rasc_pkg::SQ_IDLE:      if (item_valid_i) item_q <= item_i;
      rasc_pkg::SQ_CMP_L:     lhs_q <= prod[W-1:0];
      rasc_pkg::SQ_CMP_R:     rhs_q <= prod[W-1:0];
      rasc_pkg::SQ_GCD1_WAIT: g_q <= gcd_rsp.g[DW-1:0];
      rasc_pkg::SQ_DIVA_WAIT: fa_q <= div_rsp.quo[DW-1:0];
      rasc_pkg::SQ_DIVB_WAIT: fb_q <= div_rsp.quo[DW-1:0];
      rasc_pkg::SQ_MUL_A:     pa_q <= prod[W-1:0];
      rasc_pkg::SQ_MUL_B:     pb_q <= prod[W-1:0];
      rasc_pkg::SQ_MUL_DEN:   den_q <= prod[W-1:0];
      rasc_pkg::SQ_SUM: begin
        neg_q <= num[W-1];
        mag_q <= num[W-1] ? (W'(0) - num) : num;
      end
      rasc_pkg::SQ_GCD2_WAIT: d_q <= gcd_rsp.g;
      rasc_pkg::SQ_DIVN_WAIT: rmag_q <= div_rsp.quo;
      rasc_pkg::SQ_DIVD_WAIT: rden_q <= div_rsp.quo;
      rasc_pkg::SQ_WRITE: begin
        if (out_free) begin
          if (item_q.zero_den) begin
            out_num_q    <= '0;
            out_den_q    <= DW'(1);
            out_lt_q     <= 1'b0;
            out_eq_q     <= 1'b0;
            out_gt_q     <= 1'b0;
            out_status_q <= rasc_pkg::ST_ZERO_DEN;
          end else begin
            out_lt_q <= lhs_q < rhs_q;
            out_eq_q <= lhs_q == rhs_q;
            out_gt_q <= lhs_q > rhs_q;
            if (ovf) begin
              out_num_q    <= '0;
              out_den_q    <= DW'(1);
              out_status_q <= rasc_pkg::ST_OVERFLOW;
            end else begin
              out_num_q    <= sn[NW-1:0];
              out_den_q    <= rden_q[DW-1:0];
              out_status_q <= rasc_pkg::ST_OK;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.res_num   = out_num_q;
  assign res_o.res_den   = out_den_q;
  assign res_o.a_less    = out_lt_q;
  assign res_o.a_equal   = out_eq_q;
  assign res_o.a_greater = out_gt_q;
  assign res_o.status    = out_status_q;

endmodule
`default_nettype wire

[src/rational_add_sub_compare_top.sv]
// top level of the rational add/sub/compare block
// usage
//   req_i carries op (0 add, 1 subtract) and two fractions a_num/a_den, b_num/b_den;
//   a request is taken when valid and ready are both high on a rising clk_i
//   res_o returns one result per request, in order: the reduced sum or difference
//   res_num/res_den, the compare flags of a against b, and a status code
//   (ok, zero input denominator, result out of range)
// sequence of work
//   a zero-denominator request skips the arithmetic and goes straight to the write;
//   any other one runs two multiplies, a gcd of the denominators, two 64-step
//   divisions, three more multiplies, a gcd of the 64-bit result and two more
//   64-step divisions, on the one-bit-a-cycle divider and the binary gcd unit;
//   one request is in work at a time
// reset
//   rst_ni low empties the request queue and the result register at once
// stalls
//   a two-entry queue keeps taking requests while the back end works; a result
//   held by a stalled receiver blocks only the next write, not the queue
`default_nettype none
`include "rational_add_sub_compare_top_macros.svh"
module rational_add_sub_compare_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rasc_req_if.sink  req_i,
  rasc_res_if.source res_o
);

  // queue to back end hand-off
  rasc_pkg::item_t item;
  logic            item_valid;
  logic            item_ready;

  // result classes seen by the checks below
  logic            res_ok, res_zero_den, res_err;
  logic [2:0]      res_flags;

  // front end: zero-denominator check and request queue
  rasc_front u_front (
    .clk_i,
    .rst_ni,
    .req_i,
    .item_o      (item),
    .item_valid_o(item_valid),
    .item_ready_i(item_ready)
  );

  // back end: arithmetic sequencer and result register
  rasc_back u_back (
    .clk_i,
    .rst_ni,
    .item_i      (item),
    .item_valid_i(item_valid),
    .item_ready_o(item_ready),
    .res_o
  );

  assign res_flags    = {res_o.a_less, res_o.a_equal, res_o.a_greater};
  assign res_ok       = res_o.valid && (res_o.status == rasc_pkg::ST_OK);
  assign res_zero_den = res_o.valid && (res_o.status == rasc_pkg::ST_ZERO_DEN);
  assign res_err      = res_o.valid && (res_o.status != rasc_pkg::ST_OK);

  // exactly one compare flag on a good result
  `RASC_ASSERT_IMP(a_flags_onehot, res_ok, $onehot(res_flags))
  // no compare flags with a zero denominator
  `RASC_ASSERT_IMP(a_zero_den_flags, res_zero_den, res_flags == 3'b000)
  // any error gives 0/1
  `RASC_ASSERT_IMP(a_err_fixed, res_err, (res_o.res_num == '0) && (res_o.res_den == 31'd1))
  // back end is busy right after it takes a request
  `RASC_ASSERT_NXT(a_back_busy, item_valid && item_ready, !item_ready)

endmodule
`default_nettype wire

[tb/sv/tb_rational_add_sub_compare_top.sv]
// testbench for the rational add/sub/compare block: directed and random requests
`timescale 1ns / 100ps
`default_nettype none

module tb_rational_add_sub_compare_top;

  // one expected result as the block should return it
  typedef struct {
    logic signed [rasc_pkg::NUM_W-1:0] num;
    logic [rasc_pkg::DEN_W-1:0]        den;
    logic                              lt;
    logic                              eq;
    logic                              gt;
    rasc_pkg::status_e                 st;
  } fraction_res_t;

  // holds predicted fractions in request order and checks returned ones
  class fraction_scoreboard;
    fraction_res_t pending[$];
    int unsigned   n_fail;
    int unsigned   n_seen;
    int unsigned   n_status[3];

    function automatic logic [63:0] gcd64(logic [63:0] u, logic [63:0] v);
      logic [63:0] t;
      while (v != 0) begin
        t = u % v;
        u = v;
        v = t;
      end
      return u;
    endfunction

    // work out the exact sum or difference, reduced, plus the compare flags
    function automatic void note_request(logic op, logic signed [31:0] an, logic [30:0] ad,
                                         logic signed [31:0] bn, logic [30:0] bd);
      fraction_res_t    r;
      longint           lhs, rhs, g, fa, fb, num, den, maxv, sn;
      logic [63:0]      mag, d, rmag, rden;
      r.num = 0; r.den = 1; r.lt = 0; r.eq = 0; r.gt = 0; r.st = rasc_pkg::ST_OK;
      if (ad == 0 || bd == 0) begin
        r.st = rasc_pkg::ST_ZERO_DEN;
      end else begin
        lhs = longint'(an) * longint'({1'b0, bd});
        rhs = longint'(bn) * longint'({1'b0, ad});
        r.lt = lhs < rhs;
        r.eq = lhs == rhs;
        r.gt = lhs > rhs;
        g = gcd64(64'(ad), 64'(bd));
        fa = longint'({1'b0, bd}) / g;
        fb = longint'({1'b0, ad}) / g;
        num = op ? (longint'(an) * fa - longint'(bn) * fb)
                 : (longint'(an) * fa + longint'(bn) * fb);
        den = fb * longint'({1'b0, bd});
        mag = num < 0 ? 64'(-num) : 64'(num);
        d = gcd64(mag, 64'(den));
        maxv = (longint'(1) << (rasc_pkg::VALUE_BITS - 1)) - 1;
        rmag = mag / d;
        rden = 64'(den) / d;
        if (rmag > 64'(maxv) + 1) begin
          r.st = rasc_pkg::ST_OVERFLOW;
        end else begin
          sn = num < 0 ? -longint'(rmag) : longint'(rmag);
          if (sn > maxv || sn < -maxv - 1 || rden > 64'(maxv)) begin
            r.st = rasc_pkg::ST_OVERFLOW;
          end else begin
            r.num = sn[31:0];
            r.den = rden[30:0];
          end
        end
      end
      pending.push_back(r);
    endfunction

    function automatic void check_result(logic signed [31:0] num, logic [30:0] den,
                                         logic lt, logic eq, logic gt, logic [1:0] st);
      fraction_res_t e;
      n_seen++;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        n_fail++;
        return;
      end
      e = pending.pop_front();
      if (st < 3) n_status[st]++;
      if (num !== e.num) begin
        $error("res_num expected %0d actual %0d", e.num, num); n_fail++;
      end
      if (den !== e.den) begin
        $error("res_den expected %0d actual %0d", e.den, den); n_fail++;
      end
      if (lt !== e.lt) begin
        $error("a_less expected %0b actual %0b", e.lt, lt); n_fail++;
      end
      if (eq !== e.eq) begin
        $error("a_equal expected %0b actual %0b", e.eq, eq); n_fail++;
      end
      if (gt !== e.gt) begin
        $error("a_greater expected %0b actual %0b", e.gt, gt); n_fail++;
      end
      if (st !== e.st) begin
        $error("status expected %0d actual %0d", e.st, st); n_fail++;
      end
    endfunction
  endclass

  localparam int unsigned N_RANDOM    = 450;
  // room for the worst-case time of every request, plus stalls and gaps, several times over
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic clk_i;
  logic rst_ni;
  int unsigned cycle_cnt = 0;

  rasc_req_if req_if ();
  rasc_res_if res_if ();

  rational_add_sub_compare_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .res_o (res_if.source)
  );

  fraction_scoreboard sb;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog on the cycle count
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: stalls on its own pattern, with stall-free stretches
  int unsigned stall_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_phase  <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:8] == 2'd0) res_if.ready <= 1'b1;     // no stalls here
      else if (stall_phase[9:8] == 2'd1) res_if.ready <= ($urandom_range(0, 3) != 0);
      else res_if.ready <= ($urandom_range(0, 99) < 30);      // heavy back pressure
    end
  end

  // check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.res_num, res_if.res_den, res_if.a_less, res_if.a_equal,
                      res_if.a_greater, res_if.status);
  end

  // burst counter for the sender: items left in the burst before a gap
  int unsigned burst_left;

  // present one request and hold it until taken
  task automatic send_request(logic op, logic signed [31:0] an, logic [30:0] ad,
                              logic signed [31:0] bn, logic [30:0] bd);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      // valid drops only for a real gap between bursts
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.a_num <= an;
    req_if.a_den <= ad;
    req_if.b_num <= bn;
    req_if.b_den <= bd;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(op, an, ad, bn, bd);
  endtask

  // random numerator: mostly small, sometimes full range or an extreme
  function automatic logic signed [31:0] rand_num();
    case ($urandom_range(0, 5))
      0, 1:    return $signed($urandom_range(0, 40)) - 20;
      2:       return $signed($urandom_range(0, 20000)) - 10000;
      3:       return $urandom();
      4:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  // random denominator: mostly small and non-zero, rarely zero
  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 9))
      0:       return 31'd0;
      1, 2:    return 31'($urandom_range(1, 12));
      3:       return 31'($urandom());
      4:       return 31'h7fffffff;
      5:       return 31'($urandom_range(1, 16)) * 31'($urandom_range(1, 4096));
      default: return 31'($urandom_range(1, 1000));
    endcase
  endfunction

  logic signed [31:0] rn;
  logic [30:0]        rd;
  int unsigned        i, wait_cnt;

  initial begin
    sb = new();
    burst_left   = 0;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.op    = 1'b0;
    req_if.a_num = '0;
    req_if.a_den = '0;
    req_if.b_num = '0;
    req_if.b_den = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: both operations, zero denominators, extremes, equal values
    send_request(1'b0, 32'sd1, 31'd2, 32'sd1, 31'd3);
    send_request(1'b1, 32'sd1, 31'd2, 32'sd1, 31'd3);
    send_request(1'b1, 32'sd3, 31'd6, 32'sd1, 31'd2);         // zero result as 0/1
    send_request(1'b0, 32'sd2, 31'd4, -32'sd1, 31'd2);
    send_request(1'b0, 32'sd5, 31'd0, 32'sd1, 31'd3);         // zero denominator a
    send_request(1'b1, 32'sd5, 31'd7, 32'sd1, 31'd0);         // zero denominator b
    send_request(1'b0, 32'sd0, 31'd0, 32'sd0, 31'd0);
    send_request(1'b0, 32'sh7fffffff, 31'd1, 32'sh7fffffff, 31'd1); // overflow
    send_request(1'b1, 32'sh80000000, 31'd1, 32'sd1, 31'd1);  // overflow low
    send_request(1'b0, 32'sh80000000, 31'd1, 32'sd0, 31'd1);  // most negative fits
    send_request(1'b1, 32'sh80000000, 31'd1, 32'sh80000000, 31'd1);
    send_request(1'b0, 32'sd1, 31'h7fffffff, 32'sd1, 31'h7ffffffe); // denominator overflow
    send_request(1'b0, 32'sd1, 31'h7fffffff, 32'sd1, 31'h7fffffff);
    send_request(1'b1, 32'sh7fffffff, 31'h7fffffff, 32'sh80000000, 31'h7fffffff);
    send_request(1'b0, -32'sd1, 31'h7fffffff, 32'sh80000000, 31'd1);
    send_request(1'b1, 32'shffffffff, 31'h55555555, 32'sh55555555, 31'h2aaaaaaa);
    send_request(1'b0, 32'sh2aaaaaaa, 31'h2aaaaaaa, 32'shaaaaaaaa, 31'h55555555);
    send_request(1'b1, 32'sd7, 31'd13, 32'sd7, 31'd13);
    send_request(1'b0, -32'sd6, 31'd9, 32'sd4, 31'd6);

    // random part: mostly well-formed fractions with varied content
    for (i = 0; i < N_RANDOM; i++) begin
      rn = rand_num();
      rd = rand_den();
      if ($urandom_range(0, 7) == 0)
        send_request(1'($urandom_range(0, 1)), rn, rd, rn, rd);   // equal operands
      else
        send_request(1'($urandom_range(0, 1)), rn, rd, rand_num(), rand_den());
    end
    req_if.valid <= 1'b0;

    // drain, then a tail for anything still in flight
    wait_cnt = 0;
    while (sb.pending.size() != 0) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (600) @(posedge clk_i);

    $display("%0d requests checked: %0d ok, %0d zero denominator, %0d overflow",
             sb.n_seen, sb.n_status[0], sb.n_status[1], sb.n_status[2]);
    $display("covered add and subtract, compare flags, extremes and random stalls");
    if (sb.n_fail == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
